@@ sv/pcesl_pkg.sv @@
// Package for the pulse channel envelope/sweep/length core.
// Holds item types, opcodes, channel state and the length lookup table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcesl_pkg;

  localparam int LENGTH_TABLE_DEPTH = 32;
  localparam int LenIdxW = $clog2(LENGTH_TABLE_DEPTH);

  localparam logic [11:0] PERIOD_MAX = 12'h7FF;
  localparam logic [11:0] PERIOD_MIN = 12'd8;
  localparam logic [3:0]  DECAY_TOP  = 4'd15;

  typedef enum logic [2:0] {
    OP_CONTROL = 3'd0,
    OP_SWEEP   = 3'd1,
    OP_TIMER_LO = 3'd2,
    OP_TIMER_HI = 3'd3,
    OP_ENABLE  = 3'd4,
    OP_QUARTER = 3'd5,
    OP_HALF    = 3'd6,
    OP_NONE    = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  volume;
    logic [3:0]  envelope_level;
    logic [11:0] timer_period;
    logic        length_active;
    logic [1:0]  duty_mode;
    logic        muted;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  duty_sel;
    logic        loop_flag;
    logic        const_volume_flag;
    logic [3:0]  volume_reload;
    logic        env_start;
    logic [4:0]  env_divider;
    logic [3:0]  env_decay;
    logic        sweep_on;
    logic [3:0]  sweep_period;
    logic        sweep_negate;
    logic [2:0]  sweep_shift;
    logic [3:0]  sweep_divider;
    logic        sweep_reload;
    logic [11:0] period_reg;
    logic [7:0]  length_count;
    logic        channel_enabled;
  } chan_state_t;

  function automatic logic [7:0] length_lookup(input logic [LenIdxW-1:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:  val = 8'd10;   5'd1:  val = 8'd254;  5'd2:  val = 8'd20;
      5'd3:  val = 8'd2;    5'd4:  val = 8'd40;   5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;   5'd7:  val = 8'd6;    5'd8:  val = 8'd160;
      5'd9:  val = 8'd8;    5'd10: val = 8'd60;   5'd11: val = 8'd10;
      5'd12: val = 8'd14;   5'd13: val = 8'd12;   5'd14: val = 8'd26;
      5'd15: val = 8'd14;   5'd16: val = 8'd12;   5'd17: val = 8'd16;
      5'd18: val = 8'd24;   5'd19: val = 8'd18;   5'd20: val = 8'd48;
      5'd21: val = 8'd20;   5'd22: val = 8'd96;   5'd23: val = 8'd22;
      5'd24: val = 8'd192;  5'd25: val = 8'd24;   5'd26: val = 8'd72;
      5'd27: val = 8'd26;   5'd28: val = 8'd16;   5'd29: val = 8'd28;
      5'd30: val = 8'd32;   default: val = 8'd30;
    endcase
    return val;
  endfunction

  function automatic logic period_muted(input logic [11:0] p);
    return (p > PERIOD_MAX) || (p < PERIOD_MIN);
  endfunction

endpackage

`default_nettype wire

@@ sv/pcesl_step.sv @@
// Next-state and result logic for one item of the pulse channel.
// Depends on pcesl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcesl_step (
  input  var pcesl_pkg::chan_state_t cur,
  input  var pcesl_pkg::in_item_t    item,
  input  var logic                   is_first_pulse,
  output pcesl_pkg::chan_state_t     nxt,
  output pcesl_pkg::out_item_t       res
);
  import pcesl_pkg::*;

  logic [11:0] delta;
  logic [11:0] swept;
  logic        muted_now;

  // Sweep target from the current period
  always_comb begin
    delta = cur.period_reg >> cur.sweep_shift;
    if (cur.sweep_negate) begin
      swept = cur.period_reg - delta - {11'd0, is_first_pulse};
    end else begin
      swept = cur.period_reg + delta;
    end
  end

  always_comb begin
    nxt = cur;
    unique case (opcode_t'(item.opcode))
      OP_CONTROL: begin
        nxt.duty_sel          = item.data[7:6];
        nxt.loop_flag         = item.data[5];
        nxt.const_volume_flag = item.data[4];
        nxt.volume_reload     = item.data[3:0];
      end
      OP_SWEEP: begin
        nxt.sweep_on     = item.data[7];
        nxt.sweep_period = {1'b0, item.data[6:4]} + 4'd1;
        nxt.sweep_negate = item.data[3];
        nxt.sweep_shift  = item.data[2:0];
        nxt.sweep_reload = 1'b1;
      end
      OP_TIMER_LO: begin
        nxt.period_reg = {1'b0, cur.period_reg[10:8], item.data};
      end
      OP_TIMER_HI: begin
        nxt.period_reg = {1'b0, item.data[2:0], cur.period_reg[7:0]};
        if (cur.channel_enabled) begin
          nxt.length_count = length_lookup(item.data[7:3]);
        end
        nxt.env_start = 1'b1;
      end
      OP_ENABLE: begin
        nxt.channel_enabled = item.data[0];
        if (!item.data[0]) begin
          nxt.length_count = 8'd0;
        end
      end
      OP_QUARTER: begin
        if (cur.env_start) begin
          nxt.env_divider = {1'b0, cur.volume_reload} + 5'd1;
          nxt.env_decay   = DECAY_TOP;
          nxt.env_start   = 1'b0;
        end else if (cur.env_divider <= 5'd1) begin
          if (cur.loop_flag && cur.env_decay == 4'd0) begin
            nxt.env_decay = DECAY_TOP;
          end else if (cur.env_decay != 4'd0) begin
            nxt.env_decay = cur.env_decay - 4'd1;
          end
          nxt.env_divider = {1'b0, cur.volume_reload} + 5'd1;
        end else begin
          nxt.env_divider = cur.env_divider - 5'd1;
        end
      end
      OP_HALF: begin
        if (!cur.loop_flag && cur.length_count != 8'd0) begin
          nxt.length_count = cur.length_count - 8'd1;
        end
        if (cur.sweep_divider == 4'd0 && cur.sweep_on && !period_muted(cur.period_reg)) begin
          nxt.period_reg = swept;
        end
        if (cur.sweep_divider == 4'd0 || cur.sweep_reload) begin
          nxt.sweep_divider = cur.sweep_period;
          nxt.sweep_reload  = 1'b0;
        end else begin
          nxt.sweep_divider = cur.sweep_divider - 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    muted_now          = period_muted(nxt.period_reg);
    res.volume         = muted_now ? 4'd0 : nxt.volume_reload;
    res.envelope_level = nxt.env_decay;
    res.timer_period   = nxt.period_reg;
    res.length_active  = (nxt.length_count != 8'd0);
    res.duty_mode      = nxt.duty_sel;
    res.muted          = muted_now;
  end

endmodule

`default_nettype wire

@@ sv/pulse_channel_envelope_sweep_length_core.sv @@
// Top level of the pulse channel envelope/sweep/length core.
// Depends on pcesl_pkg and pcesl_step.
`timescale 1ns / 1ps
`default_nettype none

// Pulse channel of a sound chip: each input item is a register write
// (control, sweep, timer low, timer high with length index, enable) or a
// quarter/half frame clock, and each yields exactly one result item with
// volume, envelope level, period, length status, duty and mute flag after
// that item's update; the unused opcode changes nothing. An accepted item
// lands in an input register; one short combinational step computes the
// state update and result, captured in the output register, so the block
// sustains one item per clock while not stalled. The input side
// stalls only when the input register is full and the output register is
// full and stalled. cfg_write/cfg_data set the first-pulse flag (ones'
// complement sweep negation); write it only while the block is idle.
module pulse_channel_envelope_sweep_length_core (
  input  var logic                 clk,
  input  var logic                 rst,
  input  var logic                 cfg_write,
  input  var logic                 cfg_data,
  input  var logic                 in_valid,
  output logic                     in_stall,
  input  var pcesl_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  var logic                 out_stall,
  output pcesl_pkg::out_item_t     out_item
);
  import pcesl_pkg::*;

  logic        is_first_pulse;
  chan_state_t state;
  chan_state_t state_next;
  out_item_t   result;
  in_item_t    hold_item;
  logic        hold_valid;
  logic        advance;

  // Move the held item into the output register when that register is free
  // or is being drained this cycle.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_first_pulse <= 1'b0;
    end else if (cfg_write) begin
      is_first_pulse <= cfg_data;
    end
  end

  // Input register: hold the accepted item until it can be processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_item <= in_item;
    end
  end

  pcesl_step u_step (
    .cur            (state),
    .item           (hold_item),
    .is_first_pulse (is_first_pulse),
    .nxt            (state_next),
    .res            (result)
  );

  // Channel state advances only as an item moves to the output register.
  // Everything resets to zero except the sweep period, which starts at one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{sweep_period: 4'd1, default: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/pcesl_monitor.sv @@
// Channel monitor for the pulse channel core: predicts each result item and
// checks the output stream against it. Depends on pcesl_pkg.
`timescale 1ns / 1ps

module pcesl_monitor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  pcesl_pkg::in_item_t  in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  pcesl_pkg::out_item_t out_item,
  output int                   mismatches,
  output int                   outstanding
);
  import pcesl_pkg::*;

  // Length counter load values, entry 0 in the low byte.
  localparam logic [255:0] LENGTH_LOADS = {
    8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
    8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
    8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8, 8'd160,
    8'd6, 8'd80, 8'd4, 8'd40, 8'd2, 8'd20, 8'd254, 8'd10
  };

  chan_state_t chan;
  logic        first_pulse;
  out_item_t   channel_results[$];
  out_item_t   want;
  int          result_count;

  function automatic logic period_out_of_range(input logic [11:0] p);
    return (p > 12'h7FF) || (p < 12'd8);
  endfunction

  // Apply one item to the channel copy and return the state it reports.
  function automatic out_item_t advance_channel(input in_item_t item);
    logic [7:0]  d;
    logic [11:0] delta;
    out_item_t   res;
    d = item.data;
    case (opcode_t'(item.opcode))
      OP_CONTROL: begin
        chan.duty_sel          = d[7:6];
        chan.loop_flag         = d[5];
        chan.const_volume_flag = d[4];
        chan.volume_reload     = d[3:0];
      end
      OP_SWEEP: begin
        chan.sweep_on     = d[7];
        chan.sweep_period = {1'b0, d[6:4]} + 4'd1;
        chan.sweep_negate = d[3];
        chan.sweep_shift  = d[2:0];
        chan.sweep_reload = 1'b1;
      end
      OP_TIMER_LO: chan.period_reg = {1'b0, chan.period_reg[10:8], d};
      OP_TIMER_HI: begin
        chan.period_reg = {1'b0, d[2:0], chan.period_reg[7:0]};
        if (chan.channel_enabled)
          chan.length_count = LENGTH_LOADS[d[7:3]*8 +: 8];
        chan.env_start = 1'b1;
      end
      OP_ENABLE: begin
        chan.channel_enabled = d[0];
        if (!d[0]) chan.length_count = 8'd0;
      end
      OP_QUARTER: begin
        if (chan.env_start) begin
          chan.env_divider = {1'b0, chan.volume_reload} + 5'd1;
          chan.env_decay   = 4'd15;
          chan.env_start   = 1'b0;
        end else if (chan.env_divider <= 5'd1) begin
          if (chan.loop_flag && chan.env_decay == 4'd0)
            chan.env_decay = 4'd15;
          else if (chan.env_decay != 4'd0)
            chan.env_decay = chan.env_decay - 4'd1;
          chan.env_divider = {1'b0, chan.volume_reload} + 5'd1;
        end else begin
          chan.env_divider = chan.env_divider - 5'd1;
        end
      end
      OP_HALF: begin
        if (!chan.loop_flag && chan.length_count != 8'd0)
          chan.length_count = chan.length_count - 8'd1;
        if (chan.sweep_divider == 4'd0 && chan.sweep_on
            && !period_out_of_range(chan.period_reg)) begin
          delta = chan.period_reg >> chan.sweep_shift;
          if (chan.sweep_negate)
            chan.period_reg = chan.period_reg - delta - {11'd0, first_pulse};
          else
            chan.period_reg = chan.period_reg + delta;
        end
        if (chan.sweep_divider == 4'd0 || chan.sweep_reload) begin
          chan.sweep_divider = chan.sweep_period;
          chan.sweep_reload  = 1'b0;
        end else begin
          chan.sweep_divider = chan.sweep_divider - 4'd1;
        end
      end
      default: ;
    endcase
    res.muted          = period_out_of_range(chan.period_reg);
    res.volume         = res.muted ? 4'd0 : chan.volume_reload;
    res.envelope_level = chan.env_decay;
    res.timer_period   = chan.period_reg;
    res.length_active  = (chan.length_count != 8'd0);
    res.duty_mode      = chan.duty_sel;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                result_count, field, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chan                = '0;
      chan.sweep_period   = 4'd1;
      first_pulse         = 1'b0;
      channel_results.delete();
      mismatches          = 0;
      outstanding         = 0;
      result_count        = 0;
    end else begin
      // Drain first so an item accepted this edge never matches itself.
      if (out_valid && !out_stall) begin
        if (channel_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = channel_results.pop_front();
          check_field("volume", out_item.volume, want.volume);
          check_field("envelope_level", out_item.envelope_level, want.envelope_level);
          check_field("timer_period", out_item.timer_period, want.timer_period);
          check_field("length_active", out_item.length_active, want.length_active);
          check_field("duty_mode", out_item.duty_mode, want.duty_mode);
          check_field("muted", out_item.muted, want.muted);
        end
        result_count++;
      end
      if (cfg_write) first_pulse = cfg_data;
      if (in_valid && !in_stall) channel_results.push_back(advance_channel(in_item));
      outstanding = channel_results.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the pulse channel core: drives register writes and frame
// clocks with random gaps and stalls. Depends on pcesl_pkg, pcesl_monitor.
`timescale 1ns / 1ps

module tb_top;
  import pcesl_pkg::*;

  localparam int PHASE_ITEMS    = 300;  // random items per config phase
  localparam int LONG_HOLD      = 90;   // receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake at all

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  int         mismatches;
  int         outstanding;

  // Shared between the sender and receiver processes.
  logic       calm;      // when set, neither side idles
  logic       hold_rx;   // sender asks receiver for one long hold-off
  int         items_sent;
  int         idle_cycles;

  pulse_channel_envelope_sweep_length_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  pcesl_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: for every result item draw a random hold-off, none while calm,
  // then take exactly one item. All changes land on the falling edge so the
  // block sees a settled stall at the next rising edge.
  initial begin : receiver
    int hold_len;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold_len = calm ? 0 : $urandom_range(0, 11);
      if (hold_rx) begin
        // Long hold-off: the sender keeps offering, so the block fills
        // up and must stall its input side.
        hold_len = LONG_HOLD;
        hold_rx  = 1'b0;
      end
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Offer one item after a random gap and hold it until accepted. Valid
  // stays high into the next item when no gap is drawn.
  task automatic send_item(input opcode_t op, input logic [7:0] d);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= '{opcode: op, data: d};
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every expected result has come, then let
  // the pipeline settle before anything else happens.
  task automatic drain;
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_first_pulse(input logic v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Extremes, every opcode, and the corner cases of the channel: unused
  // opcode, clocks straight out of reset, envelope start and divider
  // reload at zero, sweep doubling to a muted period, timer low clearing
  // bit 11, shift-zero negation, length load while disabled, loop flag
  // holding the length counter.
  task automatic directed_walk;
    send_item(OP_NONE, 8'hFF);
    send_item(OP_HALF, 8'h00);
    send_item(OP_QUARTER, 8'hFF);
    send_item(OP_ENABLE, 8'h01);
    send_item(OP_CONTROL, 8'hFF);
    send_item(OP_TIMER_LO, 8'hFF);
    send_item(OP_TIMER_HI, 8'h0F);
    send_item(OP_QUARTER, 8'h00);
    send_item(OP_QUARTER, 8'h00);
    send_item(OP_CONTROL, 8'h00);
    send_item(OP_QUARTER, 8'h00);
    send_item(OP_QUARTER, 8'h00);
    send_item(OP_SWEEP, 8'h80);
    send_item(OP_HALF, 8'h00);
    send_item(OP_HALF, 8'h00);
    send_item(OP_TIMER_LO, 8'h00);
    send_item(OP_SWEEP, 8'h88);
    send_item(OP_HALF, 8'h00);
    send_item(OP_TIMER_HI, 8'hF9);
    send_item(OP_SWEEP, 8'hFF);
    send_item(OP_HALF, 8'hFF);
    send_item(OP_ENABLE, 8'h00);
    send_item(OP_TIMER_HI, 8'h08);
    send_item(OP_CONTROL, 8'h20);
    send_item(OP_HALF, 8'h00);
  endtask

  // Shift-zero negation under ones' complement: period 16 goes to 0xFFF.
  // The reload flag brings the sweep divider to zero within three half
  // clocks, so the adjustment lands by the last one.
  task automatic ones_complement_wrap;
    send_item(OP_TIMER_LO, 8'h10);
    send_item(OP_TIMER_HI, 8'h00);
    send_item(OP_SWEEP, 8'h88);
    send_item(OP_HALF, 8'h00);
    send_item(OP_HALF, 8'h00);
    send_item(OP_HALF, 8'h00);
  endtask

  // One random stretch: mostly a full channel setup followed by a run of
  // frame clocks, so the envelope, sweep and length counter all get to
  // work; the rest is single noise items, unused opcode included.
  task automatic random_stretch;
    logic [7:0] d;
    int         run;
    calm = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 4) == 0) begin
      send_item(opcode_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end else begin
      d = 8'($urandom_range(0, 255));
      d[0] = ($urandom_range(0, 7) != 0);
      send_item(OP_ENABLE, d);
      send_item(OP_CONTROL, 8'($urandom_range(0, 255)));
      d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) d[7] = 1'b1;
      send_item(OP_SWEEP, d);
      send_item(OP_TIMER_LO, 8'($urandom_range(0, 255)));
      send_item(OP_TIMER_HI, 8'($urandom_range(0, 255)));
      run = $urandom_range(4, 16);
      repeat (run) begin
        if ($urandom_range(0, 2) == 0)
          send_item(OP_QUARTER, 8'($urandom_range(0, 255)));
        else
          send_item(OP_HALF, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    int phase_start;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_data    = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    calm        = 1'b0;
    hold_rx     = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Four phases alternate the first-pulse flag: 0, 1, 0, 1.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_first_pulse(phase[0]);
      @(negedge clk);
      if (phase == 0) directed_walk();
      if (phase[0]) ones_complement_wrap();
      if (phase == 1) hold_rx = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        random_stretch();
        // In phase 2, around mid-phase, pause the sender until the output side is empty.
        if (phase == 2 && items_sent - phase_start >= PHASE_ITEMS / 2
            && items_sent - phase_start < PHASE_ITEMS / 2 + 20)
          drain();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
